/* rtl/assert_macros.svh */
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TLP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tlp_pkg.sv */
// shared types, constants and helpers of the triplet map line permuter
`timescale 1ns / 1ps

package tlp_pkg;

  localparam int LineCells  = 256;
  localparam int ValueBits  = 64;
  localparam int NumValues  = 5;
  localparam int FieldBits  = 64;
  localparam int CfgIdxBits = 1;
  localparam int CfgDataBits = 9;

  localparam logic [CfgDataBits-1:0] CellsInUseReset = 9'd256;

  localparam logic [CfgIdxBits-1:0] CFG_LINE_VALID   = 1'b0;
  localparam logic [CfgIdxBits-1:0] CFG_CELLS_IN_USE = 1'b1;

  // value slots inside one cell row
  localparam int VDensity   = 0;
  localparam int VMomentumX = 1;
  localparam int VMomentumY = 2;
  localparam int VMomentumZ = 3;
  localparam int VEnergy    = 4;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_APPLY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_INTERVAL = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_BAD_SIZE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [7:0]           cell_index;
    logic [7:0]           range_low;
    logic [7:0]           range_high;
    logic [FieldBits-1:0] density_in;
    logic [FieldBits-1:0] momentum_x_in;
    logic [FieldBits-1:0] momentum_y_in;
    logic [FieldBits-1:0] momentum_z_in;
    logic [FieldBits-1:0] energy_in;
  } cmd_t;

  typedef struct packed {
    logic [FieldBits-1:0] density_out;
    logic [FieldBits-1:0] momentum_x_out;
    logic [FieldBits-1:0] momentum_y_out;
    logic [FieldBits-1:0] momentum_z_out;
    logic [FieldBits-1:0] energy_out;
    logic                 map_applied;
    logic                 size_multiple_of_three;
    logic [1:0]           status;
  } res_t;

  // floor(n / 3) for n up to 256, reciprocal 171 / 512
  function automatic logic [7:0] div3(input logic [8:0] n);
    logic [16:0] prod;
    prod = 17'(n) * 17'd171;
    return prod[16:9];
  endfunction

endpackage

/* rtl/tlp_if.sv */
// valid/ready channel interfaces for command and result items
`timescale 1ns / 1ps

interface tlp_cmd_if;
  logic          valid;
  logic          ready;
  tlp_pkg::cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tlp_res_if;
  logic          valid;
  logic          ready;
  tlp_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/tlp_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tlp_ram #(
  parameter int Width = 64,
  parameter int Depth = 256,
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrBits-1:0]    waddr_i,
  input  logic [Width-1:0]       wdata_i,
  input  logic [AddrBits-1:0]    raddr_i,
  output logic [Width-1:0]       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/triplet_map_line_permuter_unit.sv */
// line of cells with read, write and triplet map permutation of an interval
//
//   channel   dir  handshake      content
//   cmd_i     in   valid/ready    command, cell index, interval, five values
//   res_o     out  valid/ready    five values, map flag, size flag, status
//   cfg       in   cfg_we_i       line_valid (0), cells_in_use (1)
//
// write, unused command and every rejected item: result registered in the cycle after accept
// read: the store read is registered, then the result register is loaded
// apply over n cells: a copy pass and then a permute pass over the n cells, each
// through one read port per memory, then the finish state loads the result
// no clearing pass after reset; a new item is taken in idle once the result register is free or being taken
// a stalled result holds the block in idle, the result register stays put
`timescale 1ns / 1ps

module triplet_map_line_permuter_unit #(
  parameter int LINE_CELLS = tlp_pkg::LineCells,
  parameter int VALUE_BITS = tlp_pkg::ValueBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tlp_cmd_if.sink                         cmd_i,
  tlp_res_if.source                       res_o,
  input  logic                            cfg_we_i,
  input  logic [tlp_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [tlp_pkg::CfgDataBits-1:0] cfg_data_i
);

  localparam int AW = (LINE_CELLS > 1) ? $clog2(LINE_CELLS) : 1;
  localparam int RW = tlp_pkg::NumValues * VALUE_BITS;
  localparam int FB = tlp_pkg::FieldBits;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_COPY,
    S_PERM,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_MID,
    PH_LAST
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic                            line_valid_q;
  logic [tlp_pkg::CfgDataBits-1:0] cells_in_use_q;

  logic [7:0] lo_q, lo_d;
  logic [8:0] n_q, n_d;
  logic [7:0] m_q, m_d;
  logic [7:0] j_q, j_d;
  logic [7:0] k_q, k_d;
  logic [7:0] src_q, src_d;

  logic          cp_wr_q, cp_wr_d;
  logic [AW-1:0] cp_waddr_q, cp_waddr_d;
  logic          st_wr_q, st_wr_d;
  logic [AW-1:0] st_waddr_q, st_waddr_d;

  logic          out_valid_q, out_valid_d;
  tlp_pkg::res_t out_q, out_d;
  logic          out_load;

  tlp_pkg::cmd_t cmd;
  logic          acc;
  logic          idx_oob;
  logic          lo_gt_hi;
  logic          hi_oob;
  logic [8:0]    n_w;
  logic [7:0]    m_w;
  logic [8:0]    r_w;
  logic [7:0]    cell_addr;
  logic          last;

  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [RW-1:0] st_wdata;
  logic [AW-1:0] st_raddr;
  logic [RW-1:0] st_rdata;
  logic [RW-1:0] cp_rdata;
  logic [RW-1:0] row_in;

  assign cmd = cmd_i.payload;
  assign cmd_i.ready = (state_q == S_IDLE) && (!out_valid_q || res_o.ready);
  assign acc = cmd_i.valid && cmd_i.ready;

  assign idx_oob  = (32'(cmd.cell_index) >= 32'(LINE_CELLS));
  assign lo_gt_hi = (cmd.range_low > cmd.range_high);
  assign hi_oob   = (32'(cmd.range_high) >= 32'(cells_in_use_q))
                    || (32'(cmd.range_high) >= 32'(LINE_CELLS));
  assign n_w = {1'b0, cmd.range_high} - {1'b0, cmd.range_low} + 9'd1;
  assign m_w = tlp_pkg::div3(n_w);
  assign r_w = n_w - {m_w, 1'b0} - {1'b0, m_w};

  assign cell_addr = lo_q + j_q;
  assign last = ({1'b0, j_q} == (n_q - 9'd1));

  assign row_in[tlp_pkg::VDensity*VALUE_BITS +: VALUE_BITS]   = cmd.density_in[VALUE_BITS-1:0];
  assign row_in[tlp_pkg::VMomentumX*VALUE_BITS +: VALUE_BITS] =
    cmd.momentum_x_in[VALUE_BITS-1:0];
  assign row_in[tlp_pkg::VMomentumY*VALUE_BITS +: VALUE_BITS] =
    cmd.momentum_y_in[VALUE_BITS-1:0];
  assign row_in[tlp_pkg::VMomentumZ*VALUE_BITS +: VALUE_BITS] =
    cmd.momentum_z_in[VALUE_BITS-1:0];
  assign row_in[tlp_pkg::VEnergy*VALUE_BITS +: VALUE_BITS]    = cmd.energy_in[VALUE_BITS-1:0];

  // store port sharing: idle commands vs copy and permute passes
  assign st_we    = st_wr_q
                    || (acc && (cmd.command == tlp_pkg::CMD_WRITE) && !idx_oob);
  assign st_waddr = st_wr_q ? st_waddr_q : AW'(cmd.cell_index);
  assign st_wdata = st_wr_q ? cp_rdata : row_in;
  assign st_raddr = (state_q == S_COPY) ? AW'(cell_addr) : AW'(cmd.cell_index);

  tlp_ram #(
    .Width (RW),
    .Depth (LINE_CELLS)
  ) u_cell_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  tlp_ram #(
    .Width (RW),
    .Depth (LINE_CELLS)
  ) u_copy_buffer (
    .clk_i   (clk_i),
    .we_i    (cp_wr_q),
    .waddr_i (cp_waddr_q),
    .wdata_i (st_rdata),
    .raddr_i (AW'(src_q)),
    .rdata_o (cp_rdata)
  );

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    lo_d       = lo_q;
    n_d        = n_q;
    m_d        = m_q;
    j_d        = j_q;
    k_d        = k_q;
    src_d      = src_q;
    cp_wr_d    = 1'b0;
    cp_waddr_d = cp_waddr_q;
    st_wr_d    = 1'b0;
    st_waddr_d = st_waddr_q;
    out_load   = 1'b0;
    out_d      = '0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (cmd.command)
            tlp_pkg::CMD_WRITE: begin
              out_load = 1'b1;
              out_d.status = idx_oob ? tlp_pkg::ST_OUT_OF_RANGE : tlp_pkg::ST_OK;
            end
            tlp_pkg::CMD_READ: begin
              if (idx_oob) begin
                out_load = 1'b1;
                out_d.status = tlp_pkg::ST_OUT_OF_RANGE;
              end else begin
                state_d = S_READ;
              end
            end
            tlp_pkg::CMD_APPLY: begin
              if (lo_gt_hi) begin
                out_load = 1'b1;
                out_d.status = tlp_pkg::ST_BAD_INTERVAL;
              end else if (!line_valid_q || hi_oob) begin
                out_load = 1'b1;
                out_d.status = tlp_pkg::ST_OUT_OF_RANGE;
              end else if ((n_w < 9'd3) || (r_w != 9'd0)) begin
                out_load = 1'b1;
                out_d.size_multiple_of_three = (r_w == 9'd0);
                out_d.status = tlp_pkg::ST_BAD_SIZE;
              end else begin
                state_d = S_COPY;
                lo_d    = cmd.range_low;
                n_d     = n_w;
                m_d     = m_w;
                j_d     = 8'd0;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_load = 1'b1;
        out_d.density_out    = FB'(st_rdata[tlp_pkg::VDensity*VALUE_BITS +: VALUE_BITS]);
        out_d.momentum_x_out = FB'(st_rdata[tlp_pkg::VMomentumX*VALUE_BITS +: VALUE_BITS]);
        out_d.momentum_y_out = FB'(st_rdata[tlp_pkg::VMomentumY*VALUE_BITS +: VALUE_BITS]);
        out_d.momentum_z_out = FB'(st_rdata[tlp_pkg::VMomentumZ*VALUE_BITS +: VALUE_BITS]);
        out_d.energy_out     = FB'(st_rdata[tlp_pkg::VEnergy*VALUE_BITS +: VALUE_BITS]);
        out_d.status         = tlp_pkg::ST_OK;
        state_d = S_IDLE;
      end
      S_COPY: begin
        // read store cell lo+j; the registered read data is written to copy entry j
        cp_wr_d    = 1'b1;
        cp_waddr_d = AW'(j_q);
        if (last) begin
          state_d = S_PERM;
          j_d     = 8'd0;
          k_d     = 8'd0;
          phase_d = PH_FIRST;
          src_d   = 8'd0;
        end else begin
          j_d = j_q + 8'd1;
        end
      end
      S_PERM: begin
        // read copy entry src(j); the registered read data is written to store cell lo+j
        st_wr_d    = 1'b1;
        st_waddr_d = AW'(cell_addr);
        if (k_q == (m_q - 8'd1)) begin
          k_d = 8'd0;
          case (phase_q)
            PH_FIRST: begin
              phase_d = PH_MID;
              src_d   = 8'(n_q - 9'd2);
            end
            PH_MID: begin
              phase_d = PH_LAST;
              src_d   = 8'd2;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end else begin
          k_d   = k_q + 8'd1;
          src_d = (phase_q == PH_MID) ? (src_q - 8'd3) : (src_q + 8'd3);
        end
        if (last) begin
          state_d = S_FIN;
        end else begin
          j_d = j_q + 8'd1;
        end
      end
      S_FIN: begin
        out_load = 1'b1;
        out_d.map_applied            = 1'b1;
        out_d.size_multiple_of_three = 1'b1;
        out_d.status                 = tlp_pkg::ST_OK;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      phase_q        <= PH_FIRST;
      line_valid_q   <= 1'b0;
      cells_in_use_q <= tlp_pkg::CellsInUseReset;
      lo_q           <= '0;
      n_q            <= '0;
      m_q            <= '0;
      j_q            <= '0;
      k_q            <= '0;
      src_q          <= '0;
      cp_wr_q        <= 1'b0;
      cp_waddr_q     <= '0;
      st_wr_q        <= 1'b0;
      st_waddr_q     <= '0;
      out_valid_q    <= 1'b0;
      out_q          <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      lo_q       <= lo_d;
      n_q        <= n_d;
      m_q        <= m_d;
      j_q        <= j_d;
      k_q        <= k_d;
      src_q      <= src_d;
      cp_wr_q    <= cp_wr_d;
      cp_waddr_q <= cp_waddr_d;
      st_wr_q    <= st_wr_d;
      st_waddr_q <= st_waddr_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        out_q <= out_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          tlp_pkg::CFG_LINE_VALID: begin
            line_valid_q <= cfg_data_i[0];
          end
          tlp_pkg::CFG_CELLS_IN_USE: begin
            cells_in_use_q <= cfg_data_i;
          end
          default: begin
            line_valid_q <= line_valid_q;
          end
        endcase
      end
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

endmodule

/* rtl/tlp_checker.sv */
// port level checks of the triplet map line permuter, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input tlp_pkg::res_t res_payload_i
);

  logic values_zero;

  assign values_zero = (res_payload_i.density_out == '0)
                       && (res_payload_i.momentum_x_out == '0)
                       && (res_payload_i.momentum_y_out == '0)
                       && (res_payload_i.momentum_z_out == '0)
                       && (res_payload_i.energy_out == '0);

  `TLP_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i, "result item dropped while stalled")
  `TLP_ASSERT_IMPL(a_map_ok, clk_i, rst_ni, res_valid_i && res_payload_i.map_applied, (res_payload_i.status == tlp_pkg::ST_OK) && res_payload_i.size_multiple_of_three, "applied map without ok status")
  `TLP_ASSERT_IMPL(a_err_clean, clk_i, rst_ni, res_valid_i && (res_payload_i.status != tlp_pkg::ST_OK), !res_payload_i.map_applied && !res_payload_i.size_multiple_of_three && values_zero, "rejected item carries data")
  `TLP_ASSERT_IMPL(a_map_no_data, clk_i, rst_ni, res_valid_i && res_payload_i.map_applied, values_zero, "applied map carries read data")

endmodule

bind triplet_map_line_permuter_unit tlp_checker u_tlp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_payload_i (res_o.payload)
);

/* dv/tb_top.sv */
// testbench of the triplet map line permuter: directed and random commands against a shadow line
`timescale 1ns / 1ps

module tb_top;
  import tlp_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned PhaseItems = 143;
  localparam int unsigned NumPhases  = 8;
  localparam logic [1:0] CmdUnused   = 2'd3;
  localparam logic [FieldBits-1:0] ValueMask = {FieldBits{1'b1}} >> (FieldBits - ValueBits);

  // shadow of the line with the queue of results still owed by the block
  class line_tracker;
    logic [FieldBits-1:0] cells [LineCells][NumValues];
    logic [FieldBits-1:0] scratch [LineCells][NumValues];
    bit          line_ok;
    int unsigned cells_in_use;
    res_t        pending_results [$];
    int unsigned errors;

    function new();
      line_ok      = 1'b0;
      cells_in_use = CellsInUseReset;
      errors       = 0;
    endfunction

    function void set_register(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
      if (idx == CFG_LINE_VALID) begin
        line_ok = data[0];
      end else if (idx == CFG_CELLS_IN_USE) begin
        cells_in_use = data;
      end
    endfunction

    function void take_command(cmd_t c);
      res_t                 r;
      logic [FieldBits-1:0] vin [NumValues];
      int unsigned          lim, lo, hi, n, m, j, k, src, idx;
      r = '0;
      vin[VDensity]   = c.density_in;
      vin[VMomentumX] = c.momentum_x_in;
      vin[VMomentumY] = c.momentum_y_in;
      vin[VMomentumZ] = c.momentum_z_in;
      vin[VEnergy]    = c.energy_in;
      idx = c.cell_index;
      if (c.command == CMD_WRITE || c.command == CMD_READ) begin
        if (idx >= LineCells) begin
          r.status = ST_OUT_OF_RANGE;
        end else if (c.command == CMD_WRITE) begin
          for (k = 0; k < NumValues; k++) cells[idx][k] = vin[k] & ValueMask;
        end else begin
          r.density_out    = cells[idx][VDensity] & ValueMask;
          r.momentum_x_out = cells[idx][VMomentumX] & ValueMask;
          r.momentum_y_out = cells[idx][VMomentumY] & ValueMask;
          r.momentum_z_out = cells[idx][VMomentumZ] & ValueMask;
          r.energy_out     = cells[idx][VEnergy] & ValueMask;
        end
      end else if (c.command == CMD_APPLY) begin
        lim = (cells_in_use > LineCells) ? LineCells : cells_in_use;
        lo  = c.range_low;
        hi  = c.range_high;
        if (lo > hi) begin
          r.status = ST_BAD_INTERVAL;
        end else if (!line_ok || hi >= lim) begin
          r.status = ST_OUT_OF_RANGE;
        end else begin
          n = hi - lo + 1;
          r.size_multiple_of_three = (n % 3 == 0);
          if (n < 3 || n % 3 != 0) begin
            r.status = ST_BAD_SIZE;
          end else begin
            m = n / 3;
            for (j = 0; j < n; j++)
              for (k = 0; k < NumValues; k++) scratch[j][k] = cells[lo + j][k];
            for (j = 0; j < n; j++) begin
              if (j < m) src = 3 * j;
              else if (j < 2 * m) src = 3 * (m - 1 - (j - m)) + 1;
              else src = 3 * (j - 2 * m) + 2;
              for (k = 0; k < NumValues; k++) cells[lo + j][k] = scratch[src][k];
            end
            r.map_applied = 1'b1;
            r.status      = ST_OK;
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result item with no command waiting at %0t", $realtime);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t: status exp %0d got %0d, applied exp %0b got %0b, %s %0b got %0b",
                   $realtime, want.status, got.status, want.map_applied, got.map_applied,
                   "mult3 exp", want.size_multiple_of_three, got.size_multiple_of_three);
          $display("  exp values %h %h %h %h %h", want.density_out, want.momentum_x_out,
                   want.momentum_y_out, want.momentum_z_out, want.energy_out);
          $display("  got values %h %h %h %h %h", got.density_out, got.momentum_x_out,
                   got.momentum_y_out, got.momentum_z_out, got.energy_out);
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_index_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  tlp_cmd_if cmd_if ();
  tlp_res_if res_if ();

  triplet_map_line_permuter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  line_tracker board = new();
  bit          cell_loaded [LineCells];
  bit          calm;
  bit          cur_lv;
  int unsigned cur_cells;
  int unsigned cycle_count;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic cmd_t shape(logic [1:0] op, int unsigned idx, int unsigned lo,
                                 int unsigned hi, int unsigned fill);
    cmd_t c;
    c.command    = op;
    c.cell_index = idx[7:0];
    c.range_low  = lo[7:0];
    c.range_high = hi[7:0];
    if (fill == 1) begin
      c.density_in    = '1;
      c.momentum_x_in = '1;
      c.momentum_y_in = '1;
      c.momentum_z_in = '1;
      c.energy_in     = '1;
    end else if (fill == 2) begin
      c.density_in    = '0;
      c.momentum_x_in = '0;
      c.momentum_y_in = '0;
      c.momentum_z_in = '0;
      c.energy_in     = '0;
    end else begin
      c.density_in    = {$urandom, $urandom};
      c.momentum_x_in = {$urandom, $urandom};
      c.momentum_y_in = {$urandom, $urandom};
      c.momentum_z_in = {$urandom, $urandom};
      c.energy_in     = {$urandom, $urandom};
    end
    return c;
  endfunction

  // mostly well-formed intervals, never touching a cell that was not written
  function automatic cmd_t make_item();
    cmd_t        c;
    int unsigned pick, lim, span, full, lo, hi, k;
    c    = shape(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), 0);
    pick = $urandom_range(0, 99);
    lim  = (cur_cells > LineCells) ? LineCells : cur_cells;
    full = (lim / 3) * 3;
    if (pick < 34) begin
      c.command = CMD_WRITE;
    end else if (pick < 62) begin
      c.command = CMD_READ;
    end else if (pick < 95) begin
      c.command = CMD_APPLY;
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 39) == 0) span = full;
        else if ($urandom_range(0, 3) == 0) span = $urandom_range(1, 12);
        else span = 3 * $urandom_range(1, 4);
        if (span > full) span = full;
        lo = $urandom_range(0, lim - span);
        hi = lo + span - 1;
        if ($urandom_range(0, 15) == 0 && lim < LineCells) hi = lim;
        c.range_low  = lo[7:0];
        c.range_high = hi[7:0];
      end
    end else begin
      c.command = CmdUnused;
    end
    if (c.command == CMD_READ && !cell_loaded[c.cell_index]) c.command = CMD_WRITE;
    if (c.command == CMD_APPLY) begin
      lo = c.range_low;
      hi = c.range_high;
      if (cur_lv && lo <= hi && hi < lim && (hi - lo + 1) % 3 == 0) begin
        for (k = lo; k <= hi; k++) begin
          if (!cell_loaded[k]) begin
            c.command    = CMD_WRITE;
            c.cell_index = k[7:0];
            break;
          end
        end
      end
    end
    return c;
  endfunction

  task automatic issue(input cmd_t c);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= c;
    do @(posedge clk_i); while (!cmd_if.ready);
    if (c.command == CMD_WRITE) cell_loaded[c.cell_index] = 1'b1;
    board.take_command(c);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic program_line(input bit lv, input int unsigned cells);
    logic [CfgDataBits-1:0] lv_word;
    lv_word     = CfgDataBits'($urandom);
    lv_word[0]  = lv;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_LINE_VALID;
    cfg_data_i  <= lv_word;
    @(posedge clk_i);
    board.set_register(CFG_LINE_VALID, lv_word);
    cfg_index_i <= CFG_CELLS_IN_USE;
    cfg_data_i  <= CfgDataBits'(cells);
    @(posedge clk_i);
    board.set_register(CFG_CELLS_IN_USE, CfgDataBits'(cells));
    cfg_we_i  <= 1'b0;
    cur_lv    = lv;
    cur_cells = cells;
    @(posedge clk_i);
  endtask

  // result side
  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      board.check_result(res_if.payload);
    end
  end

  initial begin
    int unsigned phase_lv [NumPhases]    = '{1, 1, 0, 1, 1, 1, 1, 1};
    int unsigned phase_cells [NumPhases] = '{256, 3, 256, 511, 0, 256, 257, 0};
    int unsigned p, i, cells;
    rst_ni         <= 1'b0;
    cmd_if.valid   <= 1'b0;
    cmd_if.payload <= '0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    calm           = 1'b0;
    cycle_count    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_line(1'b0, 256);
    issue(shape(CMD_WRITE, 0, 0, 0, 1));
    issue(shape(CMD_WRITE, 1, 0, 0, 2));
    issue(shape(CMD_WRITE, 255, 255, 255, 1));
    for (i = 2; i <= 8; i++) issue(shape(CMD_WRITE, i, 0, 0, 0));
    issue(shape(CMD_READ, 0, 0, 0, 0));
    issue(shape(CMD_READ, 255, 0, 0, 0));
    issue(shape(CMD_READ, 1, 0, 0, 0));
    // line not valid yet, then a reversed interval, then the unused command
    issue(shape(CMD_APPLY, 0, 0, 2, 0));
    issue(shape(CMD_APPLY, 0, 5, 3, 0));
    issue(shape(CmdUnused, 255, 255, 255, 1));
    drain();

    program_line(1'b1, 9);
    issue(shape(CMD_APPLY, 0, 0, 2, 0));
    issue(shape(CMD_APPLY, 0, 0, 8, 0));
    issue(shape(CMD_APPLY, 0, 0, 9, 0));
    issue(shape(CMD_APPLY, 0, 1, 4, 0));
    issue(shape(CMD_APPLY, 0, 2, 2, 0));
    issue(shape(CMD_APPLY, 0, 3, 4, 0));
    issue(shape(CMD_APPLY, 0, 3, 8, 0));
    issue(shape(CMD_APPLY, 0, 255, 255, 0));
    issue(shape(CMD_READ, 4, 0, 0, 0));
    issue(shape(CMD_READ, 8, 0, 0, 0));
    drain();

    for (p = 0; p < NumPhases; p++) begin
      cells = (phase_cells[p] == 0) ? $urandom_range(3, 300) : phase_cells[p];
      program_line(phase_lv[p][0], cells);
      for (i = 0; i < PhaseItems; i++) begin
        if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        if (p == 3 && i == 70) drain();
        issue(make_item());
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tlp_pkg.sv
rtl/tlp_if.sv
rtl/tlp_ram.sv
rtl/triplet_map_line_permuter_unit.sv
rtl/tlp_checker.sv
dv/tb_top.sv
